>>> sv/bpsbox_pkg.sv
// Shared constants and types for the box hit test pipeline.
// Holds operation codes, register indexes and the stage flag bundle; no dependencies.
package bpsbox_pkg;

    localparam int COORD_BITS_DEF = 16;

    // query operation codes
    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_SEG   = 2'd1;
    localparam logic [1:0] OP_BOX   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // per-item flags carried down the pipeline
    typedef struct packed {
        logic [1:0] op;
        logic       point;
        logic       box;
        logic       enclosed;
        logic [3:0] side;
    } bpsbox_flags_t;

endpackage

>>> sv/box_point_segment_box_hit_test.sv
// An accepted query's result strobe (done) comes from the output register after stage 3.
// Throughput: one query per cycle; busy is held low since the pipeline never stalls.
// The pipeline is deltas, four products, corner signs, then the output register.
// Reset (rst_n low, asynchronous) clears the rectangle registers to 0 and drops all valids.
// Depends on bpsbox_pkg.
module box_point_segment_box_hit_test
    import bpsbox_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    output logic                         done,
    output logic                         hit,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data
);

    localparam int D = COORD_BITS + 2;
    localparam int P = 2 * D;
    localparam int S = P + 1;

    localparam int C_LT = 0;
    localparam int C_RT = 1;
    localparam int C_RB = 2;
    localparam int C_LB = 3;

    function automatic logic d_neg(input logic signed [D-1:0] a);
        d_neg = a[D-1];
    endfunction

    function automatic logic d_pos(input logic signed [D-1:0] a);
        d_pos = !a[D-1] && (a != '0);
    endfunction

    function automatic logic d_opp(input logic signed [D-1:0] a, input logic signed [D-1:0] b);
        d_opp = (d_neg(a) && d_pos(b)) || (d_pos(a) && d_neg(b));
    endfunction

    // rectangle registers
    logic signed [COORD_BITS-1:0] box_left_reg;
    logic signed [COORD_BITS-1:0] box_top_reg;
    logic [COORD_BITS-2:0]        box_width_reg;
    logic [COORD_BITS-2:0]        box_height_reg;
    logic signed [COORD_BITS:0]   box_right_reg;
    logic signed [COORD_BITS:0]   box_bottom_reg;
    logic signed [COORD_BITS-1:0] cfg_sdata;
    logic                         cfg_fire;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_sdata = $signed(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_LEFT:
                begin
                    box_left_reg  <= cfg_sdata;
                    box_right_reg <= (COORD_BITS+1)'(cfg_sdata)
                                     + $signed({2'b00, box_width_reg});
                end
                CFG_TOP:
                begin
                    box_top_reg    <= cfg_sdata;
                    box_bottom_reg <= (COORD_BITS+1)'(cfg_sdata)
                                      + $signed({2'b00, box_height_reg});
                end
                CFG_WIDTH:
                begin
                    box_width_reg <= cfg_data[COORD_BITS-2:0];
                    box_right_reg <= (COORD_BITS+1)'(box_left_reg)
                                     + $signed({2'b00, cfg_data[COORD_BITS-2:0]});
                end
                CFG_HEIGHT:
                begin
                    box_height_reg <= cfg_data[COORD_BITS-2:0];
                    box_bottom_reg <= (COORD_BITS+1)'(box_top_reg)
                                      + $signed({2'b00, cfg_data[COORD_BITS-2:0]});
                end
                default:
                begin
                end
            endcase
        end
    end

    // stage 1: deltas against the box edges
    logic                 in_fire;
    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic signed [D-1:0]  s1_dx_reg, s1_dy_reg;
    logic signed [D-1:0]  s1_ty1_reg, s1_by1_reg, s1_lx1_reg, s1_rx1_reg;
    logic signed [D-1:0]  s1_ty2_reg, s1_by2_reg, s1_lx2_reg, s1_rx2_reg;
    logic signed [D-1:0]  s1_bsx_reg, s1_bsy_reg;
    logic signed [D-1:0]  s1_dx_next, s1_dy_next;
    logic signed [D-1:0]  s1_ty1_next, s1_by1_next, s1_lx1_next, s1_rx1_next;
    logic signed [D-1:0]  s1_ty2_next, s1_by2_next, s1_lx2_next, s1_rx2_next;
    logic signed [D-1:0]  s1_bsx_next, s1_bsy_next;

    assign in_fire = start && !busy;

    always_comb
    begin
        s1_dx_next  = D'(px) - D'(qx);
        s1_dy_next  = D'(py) - D'(qy);
        s1_ty1_next = D'(box_top_reg) - D'(py);
        s1_by1_next = D'(box_bottom_reg) - D'(py);
        s1_lx1_next = D'(px) - D'(box_left_reg);
        s1_rx1_next = D'(px) - D'(box_right_reg);
        s1_ty2_next = D'(box_top_reg) - D'(qy);
        s1_by2_next = D'(box_bottom_reg) - D'(qy);
        s1_lx2_next = D'(qx) - D'(box_left_reg);
        s1_rx2_next = D'(qx) - D'(box_right_reg);
        s1_bsx_next = D'(px) + D'(qx) - D'(box_left_reg);
        s1_bsy_next = D'(py) + D'(qy) - D'(box_top_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg  <= op;
        s1_dx_reg  <= s1_dx_next;
        s1_dy_reg  <= s1_dy_next;
        s1_ty1_reg <= s1_ty1_next;
        s1_by1_reg <= s1_by1_next;
        s1_lx1_reg <= s1_lx1_next;
        s1_rx1_reg <= s1_rx1_next;
        s1_ty2_reg <= s1_ty2_next;
        s1_by2_reg <= s1_by2_next;
        s1_lx2_reg <= s1_lx2_next;
        s1_rx2_reg <= s1_rx2_next;
        s1_bsx_reg <= s1_bsx_next;
        s1_bsy_reg <= s1_bsy_next;
    end

    // stage 2: cross products and compare flags
    logic                s2_valid_reg;
    bpsbox_flags_t       s2_flags_reg, s2_flags_next;
    logic signed [P-1:0] s2_pdt_reg, s2_pdb_reg, s2_pdl_reg, s2_pdr_reg;
    logic signed [P-1:0] s2_pdt_next, s2_pdb_next, s2_pdl_next, s2_pdr_next;
    logic                w_nz, h_nz;

    assign w_nz = (box_width_reg != '0);
    assign h_nz = (box_height_reg != '0);

    always_comb
    begin
        s2_pdt_next = P'(s1_dx_reg) * P'(s1_ty1_reg);
        s2_pdb_next = P'(s1_dx_reg) * P'(s1_by1_reg);
        s2_pdl_next = P'(s1_dy_reg) * P'(s1_lx1_reg);
        s2_pdr_next = P'(s1_dy_reg) * P'(s1_rx1_reg);

        s2_flags_next.op       = s1_op_reg;
        s2_flags_next.point    = !d_neg(s1_lx1_reg) && d_neg(s1_rx1_reg)
                                 && !d_pos(s1_ty1_reg) && d_pos(s1_by1_reg);
        s2_flags_next.box      = !d_pos(s1_rx1_reg) && !d_neg(s1_bsx_reg)
                                 && !d_neg(s1_by1_reg) && !d_neg(s1_bsy_reg);
        s2_flags_next.enclosed = !d_neg(s1_lx1_reg) && !d_pos(s1_rx1_reg)
                                 && !d_pos(s1_ty1_reg) && !d_neg(s1_by1_reg)
                                 && !d_neg(s1_lx2_reg) && !d_pos(s1_rx2_reg)
                                 && !d_pos(s1_ty2_reg) && !d_neg(s1_by2_reg);
        s2_flags_next.side[0] = w_nz && d_opp(s1_ty1_reg, s1_ty2_reg);
        s2_flags_next.side[1] = h_nz && d_opp(s1_rx1_reg, s1_rx2_reg);
        s2_flags_next.side[2] = w_nz && d_opp(s1_by1_reg, s1_by2_reg);
        s2_flags_next.side[3] = h_nz && d_opp(s1_lx1_reg, s1_lx2_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_flags_reg <= s2_flags_next;
        s2_pdt_reg   <= s2_pdt_next;
        s2_pdb_reg   <= s2_pdb_next;
        s2_pdl_reg   <= s2_pdl_next;
        s2_pdr_reg   <= s2_pdr_next;
    end

    // stage 3: corner sums reduced to signs
    logic                s3_valid_reg;
    bpsbox_flags_t       s3_flags_reg;
    logic [3:0]          s3_neg_reg, s3_pos_reg;
    logic [3:0]          s3_neg_next, s3_pos_next;
    logic signed [S-1:0] f_lt, f_rt, f_rb, f_lb;

    always_comb
    begin
        f_lt = S'(s2_pdt_reg) + S'(s2_pdl_reg);
        f_rt = S'(s2_pdt_reg) + S'(s2_pdr_reg);
        f_rb = S'(s2_pdb_reg) + S'(s2_pdr_reg);
        f_lb = S'(s2_pdb_reg) + S'(s2_pdl_reg);
        s3_neg_next[C_LT] = f_lt[S-1];
        s3_neg_next[C_RT] = f_rt[S-1];
        s3_neg_next[C_RB] = f_rb[S-1];
        s3_neg_next[C_LB] = f_lb[S-1];
        s3_pos_next[C_LT] = !f_lt[S-1] && (f_lt != '0);
        s3_pos_next[C_RT] = !f_rt[S-1] && (f_rt != '0);
        s3_pos_next[C_RB] = !f_rb[S-1] && (f_rb != '0);
        s3_pos_next[C_LB] = !f_lb[S-1] && (f_lb != '0);
    end

    always_ff @(posedge clk)
    begin
        s3_flags_reg <= s2_flags_reg;
        s3_neg_reg   <= s3_neg_next;
        s3_pos_reg   <= s3_pos_next;
    end

    // stage 4: select the result by operation
    logic [3:0] crossed;
    logic       seg_hit;
    logic       hit_next;
    logic       hit_reg;
    logic       done_reg;

    always_comb
    begin
        crossed[0] = (s3_neg_reg[C_RT] && s3_pos_reg[C_LT])
                     || (s3_pos_reg[C_RT] && s3_neg_reg[C_LT]);
        crossed[1] = (s3_neg_reg[C_RB] && s3_pos_reg[C_RT])
                     || (s3_pos_reg[C_RB] && s3_neg_reg[C_RT]);
        crossed[2] = (s3_neg_reg[C_LB] && s3_pos_reg[C_RB])
                     || (s3_pos_reg[C_LB] && s3_neg_reg[C_RB]);
        crossed[3] = (s3_neg_reg[C_LT] && s3_pos_reg[C_LB])
                     || (s3_pos_reg[C_LT] && s3_neg_reg[C_LB]);
        seg_hit    = (|(crossed & s3_flags_reg.side)) || s3_flags_reg.enclosed;
        case (s3_flags_reg.op)
            OP_POINT: hit_next = s3_flags_reg.point;
            OP_SEG:   hit_next = seg_hit;
            OP_BOX:   hit_next = s3_flags_reg.box;
            default:  hit_next = 1'b0;
        endcase
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
            hit_reg      <= s3_valid_reg && hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted query produced no result transfer");

    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !hit)
        else $error("hit high without a result transfer");

    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && op == OP_NONE, 4)) |-> !hit)
        else $error("unused operation reported a hit");

    a_point_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_op_reg == OP_POINT && d_neg(s1_lx1_reg)) |=> ##2 !hit)
        else $error("point left of the box reported a hit");
`endif

endmodule

>>> tb/sv/box_point_segment_box_hit_test_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_point_segment_box_hit_test: directed table, then random phases.
// Predicts hits not set in the table from its own rectangle copy. Depends on bpsbox_pkg.
module box_point_segment_box_hit_test_tb;
    import bpsbox_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int LATENCY      = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 210;
    localparam int RESET_ROWS   = 4;
    localparam logic signed [15:0] C_MIN = 16'sh8000;
    localparam logic signed [15:0] C_MAX = 16'sh7FFF;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        bit                 known;
        bit                 want;
    } query_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic                         done;
    logic                         hit;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [1:0]                   cfg_index;
    logic [COORD_BITS-1:0]        cfg_data;

    longint cur_left   = 0;
    longint cur_top    = 0;
    longint cur_width  = 0;
    longint cur_height = 0;

    bit     hit_expected[$];
    bit     row_known;
    bit     row_want;
    int     query_count;
    int     cfg_count;
    int     error_count;
    longint cycle_count;

    query_row_t dir_rows [0:21] = '{
        '{OP_POINT, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0},
        '{OP_BOX,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1},
        '{OP_SEG,   16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1},
        '{OP_NONE,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0},
        '{OP_POINT, -16'sd160, -16'sd80, 16'sd5, 16'sd5, 1'b1, 1'b1},
        '{OP_POINT, 16'sd160, -16'sd80, 16'sd0, 16'sd0, 1'b1, 1'b0},
        '{OP_POINT, -16'sd160, 16'sd80, 16'sd0, 16'sd0, 1'b1, 1'b0},
        '{OP_POINT, 16'sd159, 16'sd79, 16'sd0, 16'sd0, 1'b1, 1'b1},
        '{OP_POINT, C_MIN, C_MIN, C_MAX, C_MIN, 1'b1, 1'b0},
        '{OP_POINT, C_MAX, C_MAX, C_MIN, C_MAX, 1'b1, 1'b0},
        '{OP_SEG,   C_MIN, 16'sd0, C_MAX, 16'sd0, 1'b1, 1'b1},
        '{OP_SEG,   16'sd0, 16'sd0, 16'sd16, 16'sd16, 1'b1, 1'b1},
        '{OP_SEG,   -16'sd160, -16'sd80, 16'sd160, 16'sd80, 1'b1, 1'b1},
        '{OP_SEG,   C_MIN, C_MIN, C_MIN, C_MAX, 1'b1, 1'b0},
        '{OP_SEG,   -16'sd200, -16'sd120, -16'sd120, -16'sd40, 1'b0, 1'b0},
        '{OP_SEG,   -16'sd200, -16'sd80, 16'sd200, -16'sd80, 1'b0, 1'b0},
        '{OP_SEG,   -16'sd300, 16'sd0, -16'sd160, 16'sd0, 1'b0, 1'b0},
        '{OP_BOX,   16'sd160, 16'sd80, 16'sd0, 16'sd0, 1'b1, 1'b1},
        '{OP_BOX,   16'sd161, 16'sd80, 16'sd0, 16'sd0, 1'b1, 1'b0},
        '{OP_BOX,   16'sd0, 16'sd0, C_MIN, C_MIN, 1'b1, 1'b0},
        '{OP_BOX,   C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 1'b1},
        '{OP_NONE,  C_MAX, C_MIN, C_MAX, C_MIN, 1'b1, 1'b0}
    };

    box_point_segment_box_hit_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .px        (px),
        .py        (py),
        .qx        (qx),
        .qy        (qy),
        .done      (done),
        .hit       (hit),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int cross_sign(input longint a, input longint b,
                                      input longint c, input longint d);
        longint s;
        s = a * b + c * d;
        return (s < 0) ? -1 : ((s > 0) ? 1 : 0);
    endfunction

    function automatic bit box_hit(input logic [1:0] kind, input longint x1, input longint y1,
                                   input longint x2, input longint y2);
        longint r;
        longint b;
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint ex;
        longint ey;
        longint vx[5];
        longint vy[5];
        int     sa;
        int     sb;
        int     sc;
        int     sd;
        r = cur_left + cur_width;
        b = cur_top + cur_height;
        case (kind)
            OP_POINT: return x1 >= cur_left && y1 >= cur_top && x1 < r && y1 < b;
            OP_BOX:   return x1 <= r && x1 + x2 >= cur_left && y1 <= b && y1 + y2 >= cur_top;
            OP_SEG:
            begin
                vx = '{cur_left, r, r, cur_left, cur_left};
                vy = '{cur_top, cur_top, b, b, cur_top};
                dx = x1 - x2;
                dy = y1 - y2;
                for (int i = 0; i < 4; i++)
                begin
                    ax = vx[i];
                    ay = vy[i];
                    bx = vx[i + 1];
                    by = vy[i + 1];
                    ex = bx - ax;
                    ey = by - ay;
                    sa = cross_sign(dx, by - y1, dy, x1 - bx);
                    sb = cross_sign(dx, ay - y1, dy, x1 - ax);
                    sc = cross_sign(ex, y1 - by, ey, bx - x1);
                    sd = cross_sign(ex, y2 - by, ey, bx - x2);
                    if (sa * sb < 0 && sc * sd < 0)
                        return 1'b1;
                end
                return x1 >= cur_left && x1 <= r && y1 >= cur_top && y1 <= b &&
                       x2 >= cur_left && x2 <= r && y2 >= cur_top && y2 <= b;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEFT:   cur_left   = longint'($signed(cfg_data));
                    CFG_TOP:    cur_top    = longint'($signed(cfg_data));
                    CFG_WIDTH:  cur_width  = longint'(cfg_data[COORD_BITS-2:0]);
                    CFG_HEIGHT: cur_height = longint'(cfg_data[COORD_BITS-2:0]);
                    default:    ;
                endcase
                cfg_count++;
            end
            if (start && !busy)
            begin
                hit_expected.push_back(row_known ? row_want : box_hit(op, px, py, qx, qy));
                query_count++;
            end
            if (done)
            begin
                if (hit_expected.size() == 0)
                    report_mismatch("result strobe with no query pending");
                else
                begin
                    want = hit_expected.pop_front();
                    if (hit !== want)
                        report_mismatch($sformatf("hit %b, expected %b", hit, want));
                end
            end
        end
    end

    task automatic send_query(input logic [1:0] kind, input logic signed [15:0] x1,
                              input logic signed [15:0] y1, input logic signed [15:0] x2,
                              input logic signed [15:0] y2, input bit known, input bit want,
                              input int gap_pct);
        int taken;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        op        <= kind;
        px        <= x1;
        py        <= y1;
        qx        <= x2;
        qy        <= y2;
        row_known = known;
        row_want  = want;
        taken     = query_count;
        do @(negedge clk); while (query_count == taken);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (hit_expected.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic set_box(input logic [15:0] l, input logic [15:0] t,
                           input logic [15:0] w, input logic [15:0] h);
        logic [15:0] vals[4];
        logic [1:0]  idx[4];
        int          n;
        vals = '{l, t, w | 16'(($urandom_range(1)) << 15), h | 16'(($urandom_range(1)) << 15)};
        idx  = '{CFG_LEFT, CFG_TOP, CFG_WIDTH, CFG_HEIGHT};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            n = cfg_count;
            do @(negedge clk); while (cfg_count == n);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_near(input longint lo, input longint hi);
        logic signed [15:0] raw;
        longint             v;
        longint             pad;
        int                 pick;
        pick = $urandom_range(99);
        pad  = (hi - lo) / 4 + 8;
        if (pick < 25)
        begin
            raw = $urandom;
            v   = raw;
        end
        else if (pick < 60)
            v = (($urandom_range(1) != 0) ? hi : lo) + longint'($urandom_range(8)) - 4;
        else
            v = lo - pad + longint'($urandom_range(32'(hi - lo + 2 * pad)));
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rand_size();
        logic signed [15:0] raw;
        int                 pick;
        pick = $urandom_range(99);
        raw  = $urandom;
        if (pick < 60)
            raw = $urandom_range(2048);
        else if (pick < 80)
            raw = $urandom_range(16);
        return raw;
    endfunction

    function automatic logic [15:0] rand_edge_cfg();
        logic [15:0] raw;
        raw = $urandom;
        if ($urandom_range(1) != 0)
            raw = 16'(int'($urandom_range(4095)) - 2048);
        return raw;
    endfunction

    function automatic logic [15:0] rand_span_cfg();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return 16'($urandom_range(32767));
        else if (pick < 80)
            return 16'($urandom_range(2048));
        return 16'($urandom_range(16));
    endfunction

    task automatic send_random_query(input int gap_pct);
        logic [1:0]         kind;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        int                 pick;
        longint             r;
        longint             b;
        r    = cur_left + cur_width;
        b    = cur_top + cur_height;
        pick = $urandom_range(99);
        kind = (pick < 30) ? OP_POINT : (pick < 65) ? OP_SEG : (pick < 95) ? OP_BOX : OP_NONE;
        x1   = rand_near(cur_left, r);
        y1   = rand_near(cur_top, b);
        x2   = $urandom;
        y2   = $urandom;
        if (kind == OP_SEG)
        begin
            x2 = rand_near(cur_left, r);
            y2 = rand_near(cur_top, b);
        end
        else if (kind == OP_BOX)
        begin
            x2 = rand_size();
            y2 = rand_size();
        end
        send_query(kind, x1, y1, x2, y2, 1'b0, 1'b0, gap_pct);
    endtask

    initial
    begin
        int gaps[4];
        int gap;
        gaps        = '{0, 63, 0, 26};
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_POINT;
        px          = '0;
        py          = '0;
        qx          = '0;
        qy          = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LEFT;
        cfg_data    = '0;
        row_known   = 1'b0;
        row_want    = 1'b0;
        query_count = 0;
        cfg_count   = 0;
        error_count = 0;
        cycle_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (i == RESET_ROWS)
            begin
                drain_results();
                set_box(-16'sd160, -16'sd80, 16'd320, 16'd160);
            end
            send_query(dir_rows[i].kind, dir_rows[i].x1, dir_rows[i].y1, dir_rows[i].x2,
                       dir_rows[i].y2, dir_rows[i].known, dir_rows[i].want, 0);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_box(C_MIN, C_MIN, 16'h7FFF, 16'h7FFF);
                1:       set_box(C_MAX, C_MAX, 16'h7FFF, 16'h7FFF);
                2:       set_box(rand_edge_cfg(), rand_edge_cfg(), 16'd0, 16'd0);
                default: set_box(rand_edge_cfg(), rand_edge_cfg(), rand_span_cfg(),
                                 rand_span_cfg());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                gap = (n % 64 < 16) ? 0 : gaps[p % 4];
                send_random_query(gap);
            end
            drain_results();
        end

        if (hit_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", hit_expected.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
